// ----- rtl/hebp_pkg.sv -----
// Shared types, constants and helpers for the Huffman encoder bit packer.
// Used by hebp_code_table, hebp_packer, the top level and the checker.
package hebp_pkg;

	// Longest code the table accepts; loaded lengths are clipped to CODE_LIMIT
	localparam int MAX_CODE_LEN = 32;
	localparam int CODE_W       = 32;
	localparam int CODE_LIMIT   = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;

	localparam int LEN_W     = 6;
	localparam int SYM_W     = 8;
	localparam int KIND_W    = 2;
	localparam int BYTE_W    = 8;
	localparam int TOTAL_W   = 32;
	localparam int PEND_W    = 7;
	localparam int PCNT_W    = 3;
	localparam int ACC_W     = CODE_W + PEND_W;
	localparam int CNT_W     = $clog2(ACC_W + 1);
	localparam int DEPTH     = 1 << SYM_W;

	// Stream word layouts
	localparam int S_DATA_W  = 48;
	localparam int M_DATA_W  = 40;

	typedef enum logic [KIND_W-1:0] {
		KIND_LOAD   = 2'd0,
		KIND_ENCODE = 2'd1,
		KIND_FLUSH  = 2'd2
	} kind_t;

	typedef struct packed {
		logic [LEN_W-1:0]  len;
		logic [CODE_W-1:0] bits;
	} entry_t;

	typedef struct packed {
		logic             en;
		logic [SYM_W-1:0] addr;
		entry_t           entry;
	} tbl_wr_t;

	typedef struct packed {
		logic             en;
		logic [SYM_W-1:0] addr;
	} tbl_rd_t;

	// Clip a loaded length to the supported maximum
	function automatic logic [LEN_W-1:0] sat_len(input logic [LEN_W-1:0] len);
		if (len > LEN_W'(CODE_LIMIT))
			return LEN_W'(CODE_LIMIT);
		return len;
	endfunction

	// Keep only the low len bits of a code
	function automatic logic [CODE_W-1:0] mask_code(input logic [CODE_W-1:0] bits,
			input logic [LEN_W-1:0] len);
		logic [CODE_W-1:0] mask;
		if (len >= LEN_W'(CODE_W))
			mask = '1;
		else
			mask = ~({CODE_W{1'b1}} << len);
		return bits & mask;
	endfunction

endpackage

// ----- rtl/hebp_code_table.sv -----
// Code table: 256-entry single-write, single-read memory with registered read.
// Per-entry valid flops make unwritten entries read as zero length. Uses hebp_pkg.
module hebp_code_table (
	input  logic             clk,
	input  logic             arst_n,
	input  hebp_pkg::tbl_wr_t wr,
	input  hebp_pkg::tbl_rd_t rd,
	output hebp_pkg::entry_t  rd_entry
);

	hebp_pkg::entry_t                 mem [hebp_pkg::DEPTH];
	hebp_pkg::entry_t                 rd_data_q;
	logic [hebp_pkg::DEPTH-1:0]       vld_q;
	logic                             rd_vld_q;

	// Write and read the array
	always_ff @(posedge clk) begin
		if (wr.en)
			mem[wr.addr] <= wr.entry;
		if (rd.en)
			rd_data_q <= mem[rd.addr];
	end

	// Track written entries; reset clears them all at once
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr.en)
				vld_q[wr.addr] <= 1'b1;
			if (rd.en)
				rd_vld_q <= vld_q[rd.addr];
		end
	end

	// An unwritten entry reads as no code
	always_comb begin
		rd_entry.bits = rd_data_q.bits;
		rd_entry.len  = rd_vld_q ? rd_data_q.len : '0;
	end

endmodule

// ----- rtl/hebp_packer.sv -----
// Sequencer and shared shift unit of the bit packer, with the output register.
// Drives the code table ports; uses hebp_pkg.
module hebp_packer (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [hebp_pkg::S_DATA_W-1:0]     s_tdata,
	input  logic [hebp_pkg::KIND_W-1:0]       s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [hebp_pkg::M_DATA_W-1:0]     m_tdata,
	output logic                              m_tuser,
	output logic                              m_tlast,
	output hebp_pkg::tbl_wr_t                 tbl_wr,
	output hebp_pkg::tbl_rd_t                 tbl_rd,
	input  hebp_pkg::entry_t                  tbl_entry
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_EMIT,
		ST_FLUSH_PAD,
		ST_FLUSH_CNT
	} state_t;

	state_t                              state_q;
	logic [hebp_pkg::ACC_W-1:0]          acc_q;
	logic [hebp_pkg::CNT_W-1:0]          cnt_q;
	logic [hebp_pkg::PEND_W-1:0]         pend_q;
	logic [hebp_pkg::PCNT_W-1:0]         pcnt_q;
	logic [hebp_pkg::TOTAL_W-1:0]        total_q;
	logic                                m_valid_q;
	logic [hebp_pkg::BYTE_W-1:0]         out_byte_q;
	logic                                is_cnt_q;
	logic                                last_q;

	logic                                accept;
	hebp_pkg::kind_t                     kind;
	logic [hebp_pkg::SYM_W-1:0]          in_sym;
	logic [hebp_pkg::CODE_W-1:0]         in_code;
	logic [hebp_pkg::LEN_W-1:0]          in_len;
	logic [hebp_pkg::LEN_W-1:0]          ld_len;
	logic                                out_free;
	logic                                emit_word;
	logic [hebp_pkg::CNT_W-1:0]          sh_amt;
	logic [hebp_pkg::BYTE_W-1:0]         sh_byte;
	logic [hebp_pkg::BYTE_W-1:0]         pad_byte;
	logic [hebp_pkg::PEND_W-1:0]         pend_mask;

	// Unpack the input word
	assign accept  = s_tvalid && s_tready;
	assign kind    = hebp_pkg::kind_t'(s_tuser);
	assign in_sym  = s_tdata[7:0];
	assign in_code = s_tdata[39:8];
	assign in_len  = s_tdata[45:40];
	assign ld_len  = hebp_pkg::sat_len(in_len);

	// Table access: write on load, read on encode
	always_comb begin
		tbl_wr.en         = accept && (kind == hebp_pkg::KIND_LOAD);
		tbl_wr.addr       = in_sym;
		tbl_wr.entry.len  = ld_len;
		tbl_wr.entry.bits = hebp_pkg::mask_code(in_code, ld_len);
		tbl_rd.en         = accept && (kind == hebp_pkg::KIND_ENCODE);
		tbl_rd.addr       = in_sym;
	end

	// Shared shift unit: next byte sits just above the remaining count
	assign sh_amt    = cnt_q - hebp_pkg::CNT_W'(hebp_pkg::BYTE_W);
	assign sh_byte   = hebp_pkg::BYTE_W'(acc_q >> sh_amt);
	assign pend_mask = {hebp_pkg::PEND_W{1'b1}} >> (3'd7 - cnt_q[2:0]);
	assign pad_byte  = {pend_q, 1'b0} << (3'd7 - pcnt_q);

	assign out_free  = !m_valid_q || m_tready;

	// A byte goes into the output register this cycle
	assign emit_word = out_free && (((state_q == ST_EMIT)
			&& (cnt_q >= hebp_pkg::CNT_W'(hebp_pkg::BYTE_W)))
		|| (state_q == ST_FLUSH_PAD) || (state_q == ST_FLUSH_CNT));

	// Sequencer, accumulator and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			acc_q      <= '0;
			cnt_q      <= '0;
			pend_q     <= '0;
			pcnt_q     <= '0;
			total_q    <= '0;
			m_valid_q  <= 1'b0;
			out_byte_q <= '0;
			is_cnt_q   <= 1'b0;
			last_q     <= 1'b0;
		end else begin
			// raise the word when a byte is produced, drop it once taken
			if (emit_word)
				m_valid_q <= 1'b1;
			else if (m_tready)
				m_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (kind == hebp_pkg::KIND_ENCODE)
							state_q <= ST_LOOKUP;
						else if (kind == hebp_pkg::KIND_FLUSH)
							state_q <= ST_FLUSH_PAD;
					end
				end
				ST_LOOKUP: begin
					// merge pending bits with the looked-up code
					if (tbl_entry.len == '0) begin
						state_q <= ST_IDLE;
					end else begin
						acc_q   <= (hebp_pkg::ACC_W'(pend_q) << tbl_entry.len)
							| hebp_pkg::ACC_W'(tbl_entry.bits);
						cnt_q   <= hebp_pkg::CNT_W'(pcnt_q) + hebp_pkg::CNT_W'(tbl_entry.len);
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (cnt_q >= hebp_pkg::CNT_W'(hebp_pkg::BYTE_W)) begin
						if (out_free) begin
							out_byte_q <= sh_byte;
							is_cnt_q   <= 1'b0;
							last_q     <= (sh_amt < hebp_pkg::CNT_W'(hebp_pkg::BYTE_W));
							total_q    <= total_q + 1'b1;
							cnt_q      <= sh_amt;
						end
					end else begin
						// keep the leftover bits for the next symbol
						pend_q  <= acc_q[hebp_pkg::PEND_W-1:0] & pend_mask;
						pcnt_q  <= cnt_q[2:0];
						state_q <= ST_IDLE;
					end
				end
				ST_FLUSH_PAD: begin
					if (out_free) begin
						out_byte_q <= pad_byte;
						is_cnt_q   <= 1'b0;
						last_q     <= 1'b0;
						total_q    <= total_q + 1'b1;
						state_q    <= ST_FLUSH_CNT;
					end
				end
				ST_FLUSH_CNT: begin
					if (out_free) begin
						out_byte_q <= hebp_pkg::BYTE_W'(pcnt_q);
						is_cnt_q   <= 1'b1;
						last_q     <= 1'b1;
						total_q    <= total_q + 1'b1;
						pend_q     <= '0;
						pcnt_q     <= '0;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_valid_q;
	assign m_tdata  = {total_q, out_byte_q};
	assign m_tuser  = is_cnt_q;
	assign m_tlast  = last_q;

endmodule

// ----- rtl/huffman_encoder_bit_packer.sv -----
// A load writes the table and leaves the input ready. An encode looks up its entry, then
// emits n bytes (0 to 4), none when the symbol has no code; a flush emits a pad and a count
// byte. The shift unit gives one byte a cycle, output stalls add; input waits until done.
// Reset (arst_n low, asynchronous) clears all table entries to zero length,
// the pending bits and the byte total; no clearing pass is needed.
module huffman_encoder_bit_packer (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [hebp_pkg::S_DATA_W-1:0] s_tdata,  // symbol, code_bits, code_length, zeros
	input  logic [hebp_pkg::KIND_W-1:0]   s_tuser,  // kind[1:0]
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [hebp_pkg::M_DATA_W-1:0] m_tdata,  // out_byte[7:0], total_bytes[39:8]
	output logic                          m_tuser,  // is_bit_count
	output logic                          m_tlast
);

	hebp_pkg::tbl_wr_t tbl_wr;
	hebp_pkg::tbl_rd_t tbl_rd;
	hebp_pkg::entry_t  tbl_entry;

	hebp_code_table u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (tbl_wr),
		.rd       (tbl_rd),
		.rd_entry (tbl_entry)
	);

	hebp_packer u_packer (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.tbl_wr    (tbl_wr),
		.tbl_rd    (tbl_rd),
		.tbl_entry (tbl_entry)
	);

endmodule

// ----- rtl/hebp_checker.sv -----
// Port-level checker for the bit packer, bound to the top level.
// Uses hebp_pkg for the kind codes.
module hebp_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic [hebp_pkg::S_DATA_W-1:0] s_tdata,
	input logic [hebp_pkg::KIND_W-1:0]   s_tuser,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [hebp_pkg::M_DATA_W-1:0] m_tdata,
	input logic                          m_tuser,
	input logic                          m_tlast
);

	// Hold a stalled output word
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("output word changed while stalled");

	// The trailer count always closes its flush and never exceeds seven
	a_trailer: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast && (m_tdata[7:3] == 5'd0))
		else $error("bad trailer word");

	// A flush blocks the next input word
	a_flush_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == hebp_pkg::KIND_FLUSH) |=> !s_tready)
		else $error("input accepted during flush");

	// A load leaves the input ready for the next word
	a_load_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == hebp_pkg::KIND_LOAD) |=> s_tready)
		else $error("load stalled the input");

endmodule

bind huffman_encoder_bit_packer hebp_checker u_hebp_checker (.*);

// ----- tb/tb_top.sv -----
// Self-checking testbench for the Huffman encoder bit packer: loads code tables,
// streams encode and flush words and compares every packed byte with a local model.
// Depends on hebp_pkg and huffman_encoder_bit_packer.
module tb_top;
	import hebp_pkg::*;

	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
	localparam int QUIET_LIMIT = 3000;
	localparam int LONG_HOLD   = 250;
	localparam int END_CYCLES  = 20;

	typedef struct {
		logic [KIND_W-1:0] kind;
		logic [SYM_W-1:0]  symbol;
		logic [CODE_W-1:0] code_bits;
		logic [LEN_W-1:0]  code_length;
		bit                drain;
	} in_word_t;

	typedef struct {
		logic [BYTE_W-1:0]  out_byte;
		logic               is_bit_count;
		logic               last;
		logic [TOTAL_W-1:0] total_bytes;
	} out_word_t;

	logic                clk;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata = '0;
	logic [KIND_W-1:0]   s_tuser = '0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [M_DATA_W-1:0] m_tdata;
	logic                m_tuser;
	logic                m_tlast;

	// Words waiting to be sent, packed bytes still due, local copy of the packer
	in_word_t          word_q[$];
	out_word_t         due_bytes[$];
	in_word_t          cur_word;
	logic [CODE_W-1:0] tbl_bits[DEPTH];
	logic [LEN_W-1:0]  tbl_len[DEPTH];
	logic [PEND_W-1:0] pend_bits;
	logic [PCNT_W-1:0] pend_cnt;
	logic [TOTAL_W-1:0] byte_total;
	logic [SYM_W-1:0]  known_syms[$];

	bit in_taken;
	bit hold_req;
	int hold_cnt;
	int tx_idle_pct;
	int rx_idle_pct;
	int quiet_cycles;
	int errors;

	huffman_encoder_bit_packer DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Append one packed byte to the expected stream and bump the running total
	task automatic emit_byte(input logic [BYTE_W-1:0] b, input logic is_cnt);
		out_word_t r;
		byte_total = byte_total + 1;
		r.out_byte     = b;
		r.is_bit_count = is_cnt;
		r.last         = 1'b0;
		r.total_bytes  = byte_total;
		due_bytes = {due_bytes, r};
	endtask

	// Advance the local packer by one accepted word
	task automatic advance_packer(input in_word_t w);
		logic [LEN_W-1:0] len;
		logic [63:0]      acc;
		int               cnt;
		int               n0;
		n0 = due_bytes.size();
		case (w.kind)
			KIND_LOAD: begin
				len = (w.code_length > LEN_W'(CODE_LIMIT)) ? LEN_W'(CODE_LIMIT) : w.code_length;
				tbl_len[w.symbol]  = len;
				tbl_bits[w.symbol] = (len >= LEN_W'(CODE_W)) ? w.code_bits :
					w.code_bits & ((32'd1 << len) - 32'd1);
			end
			KIND_ENCODE: begin
				len = tbl_len[w.symbol];
				if (len != 0) begin
					acc = (64'(pend_bits) << len) | 64'(tbl_bits[w.symbol]);
					cnt = pend_cnt + len;
					while (cnt >= 8) begin
						cnt -= 8;
						emit_byte(8'(acc >> cnt), 1'b0);
					end
					pend_cnt  = PCNT_W'(cnt);
					pend_bits = PEND_W'(acc & ((64'd1 << cnt) - 64'd1));
				end
			end
			KIND_FLUSH: begin
				// pad leftover bits to a byte, then give the count of valid bits
				emit_byte(8'(16'(pend_bits) << (8 - pend_cnt)), 1'b0);
				emit_byte(8'(pend_cnt), 1'b1);
				pend_bits = '0;
				pend_cnt  = '0;
			end
			default: ;
		endcase
		if (due_bytes.size() > n0)
			due_bytes[due_bytes.size() - 1].last = 1'b1;
	endtask

	function automatic in_word_t make_word(input logic [KIND_W-1:0] kind,
			input logic [SYM_W-1:0] sym, input logic [CODE_W-1:0] bits,
			input logic [LEN_W-1:0] len);
		in_word_t w;
		w.kind        = kind;
		w.symbol      = sym;
		w.code_bits   = bits;
		w.code_length = len;
		w.drain       = 1'b0;
		return w;
	endfunction

	// Append one word to the send queue
	task automatic add_word(input in_word_t w);
		word_q = {word_q, w};
	endtask

	// Queue a pause marker: the driver holds off until every due byte has arrived
	task automatic queue_drain();
		in_word_t w;
		w = make_word(KIND_UNUSED, '0, '0, '0);
		w.drain = 1'b1;
		add_word(w);
	endtask

	task automatic queue_load(input logic [SYM_W-1:0] sym, input logic [CODE_W-1:0] bits,
			input logic [LEN_W-1:0] len);
		add_word(make_word(KIND_LOAD, sym, bits, len));
		known_syms = {known_syms, sym};
	endtask

	// Random words: mostly encodes of loaded symbols, some loads, flushes and noise
	task automatic queue_random(input int n);
		int r;
		int lr;
		logic [LEN_W-1:0] len;
		logic [SYM_W-1:0] sym;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (r < 15) begin
				lr = $urandom_range(0, 99);
				if (lr < 8)
					len = '0;
				else if (lr < 20)
					len = LEN_W'($urandom_range(33, 63));
				else if (lr < 32)
					len = LEN_W'(32);
				else
					len = LEN_W'($urandom_range(1, 31));
				queue_load(SYM_W'($urandom), $urandom, len);
			end else if (r < 85) begin
				if (known_syms.size() != 0 && $urandom_range(0, 99) < 80)
					sym = known_syms[$urandom_range(0, known_syms.size() - 1)];
				else
					sym = SYM_W'($urandom);
				add_word(make_word(KIND_ENCODE, sym, $urandom, LEN_W'($urandom)));
			end else if (r < 95) begin
				add_word(make_word(KIND_FLUSH, SYM_W'($urandom), $urandom,
					LEN_W'($urandom)));
			end else begin
				add_word(make_word(KIND_UNUSED, SYM_W'($urandom), $urandom,
					LEN_W'($urandom)));
			end
		end
	endtask

	task automatic wait_sent();
		while (word_q.size() != 0 || s_tvalid)
			@(posedge clk);
	endtask

	// Driver: offer the next word at the falling edge, hold it until taken
	always @(negedge clk) begin : drive
		logic v;
		v = s_tvalid;
		if (arst_n && (!s_tvalid || in_taken)) begin
			in_taken = 1'b0;
			v = 1'b0;
			if (word_q.size() != 0 && word_q[0].drain) begin
				if (due_bytes.size() == 0)
					void'(word_q.pop_front());
			end else if (word_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
				cur_word = word_q.pop_front();
				v = 1'b1;
				s_tdata <= {2'b00, cur_word.code_length, cur_word.code_bits, cur_word.symbol};
				s_tuser <= cur_word.kind;
			end
			s_tvalid <= v;
		end
	end

	// Receiver: random back-pressure, or a long hold when one is requested
	always @(negedge clk) begin
		if (hold_req) begin
			hold_cnt = LONG_HOLD;
			hold_req = 1'b0;
		end
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_cnt > 0) begin
			hold_cnt--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
		end
	end

	// Monitor: model accepted words, check accepted bytes, watch for a hang
	always @(posedge clk) begin : monitor
		out_word_t e;
		if (arst_n) begin
			quiet_cycles++;
			if (s_tvalid && s_tready) begin
				advance_packer(cur_word);
				in_taken = 1'b1;
				quiet_cycles = 0;
			end
			if (m_tvalid && m_tready) begin
				quiet_cycles = 0;
				if (due_bytes.size() == 0) begin
					$error("unexpected byte %0h", m_tdata[7:0]);
					errors++;
				end else begin
					e = due_bytes.pop_front();
					if (m_tdata[7:0] !== e.out_byte) begin
						$error("out_byte: expected %0h, got %0h", e.out_byte, m_tdata[7:0]);
						errors++;
					end
					if (m_tuser !== e.is_bit_count) begin
						$error("is_bit_count: expected %0d, got %0d", e.is_bit_count, m_tuser);
						errors++;
					end
					if (m_tlast !== e.last) begin
						$error("last: expected %0d, got %0d", e.last, m_tlast);
						errors++;
					end
					if (m_tdata[39:8] !== e.total_bytes) begin
						$error("total_bytes: expected %0d, got %0d", e.total_bytes,
							m_tdata[39:8]);
						errors++;
					end
				end
			end
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	initial begin
		for (int i = 0; i < DEPTH; i++) begin
			tbl_bits[i] = '0;
			tbl_len[i]  = '0;
		end
		pend_bits   = '0;
		pend_cnt    = '0;
		byte_total  = '0;
		in_taken    = 1'b0;
		hold_req    = 1'b0;
		hold_cnt    = 0;
		errors      = 0;
		quiet_cycles = 0;
		tx_idle_pct = 32;
		rx_idle_pct = 75;

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: never-loaded symbol, empty flush, extreme and overlong codes, noise
		add_word(make_word(KIND_ENCODE, 8'h00, '1, '1));
		add_word(make_word(KIND_FLUSH, 8'h00, '0, '0));
		queue_load(8'h00, 32'h0000_0001, 6'd1);
		queue_load(8'hFF, 32'hFFFF_FFFF, 6'd32);
		queue_load(8'h5A, 32'hA5A5_A5A5, 6'd63);
		queue_load(8'h3C, 32'hFFFF_FFFF, 6'd7);
		queue_load(8'h81, 32'h0000_00C3, 6'd8);
		queue_load(8'h10, 32'hDEAD_BEEF, 6'd0);
		add_word(make_word(KIND_UNUSED, 8'hFF, '1, '1));
		add_word(make_word(KIND_ENCODE, 8'h00, '0, '0));
		add_word(make_word(KIND_ENCODE, 8'hFF, '0, '0));
		add_word(make_word(KIND_ENCODE, 8'h3C, '0, '0));
		add_word(make_word(KIND_ENCODE, 8'h5A, '0, '0));
		add_word(make_word(KIND_ENCODE, 8'h81, '0, '0));
		add_word(make_word(KIND_ENCODE, 8'h10, '0, '0));
		add_word(make_word(KIND_FLUSH, 8'h00, '0, '0));
		add_word(make_word(KIND_ENCODE, 8'h3C, '0, '0));
		add_word(make_word(KIND_ENCODE, 8'h3C, '0, '0));
		add_word(make_word(KIND_ENCODE, 8'hFF, '0, '0));
		add_word(make_word(KIND_ENCODE, 8'h00, '0, '0));
		add_word(make_word(KIND_FLUSH, 8'hFF, '1, '1));
		queue_drain();

		// First random phase: sender idles lightly, receiver heavily
		queue_random(35);
		queue_drain();
		queue_random(40);
		wait_sent();

		// Second phase: the other way round
		tx_idle_pct = 75;
		rx_idle_pct = 32;
		queue_random(75);
		wait_sent();

		// Last phase: no idling; hold the receiver while long codes pile up
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		for (int i = 0; i < 4; i++)
			queue_load(SYM_W'(8'hC0 + i), $urandom, 6'd32);
		hold_req = 1'b1;
		for (int i = 0; i < 30; i++)
			add_word(make_word(KIND_ENCODE, SYM_W'(8'hC0 + $urandom_range(0, 3)),
				'0, '0));
		queue_random(25);
		wait_sent();

		while (due_bytes.size() != 0)
			@(posedge clk);
		repeat (END_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ----- huffman_encoder_bit_packer.f -----
rtl/hebp_pkg.sv
rtl/hebp_code_table.sv
rtl/hebp_packer.sv
rtl/huffman_encoder_bit_packer.sv
rtl/hebp_checker.sv
tb/tb_top.sv
